### src/rci_pkg.sv
// Shared constants, word types and saturating arithmetic for the ray/cone intersect pipeline.
package rci_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_BITS  = 32;
  localparam int IW         = 64;                 // internal word width
  localparam int AXIS_BITS  = FRAC_BITS + 2;
  localparam int SLOPE_BITS = WORD_BITS - 1;
  localparam int DIST_BITS  = WORD_BITS - 1;
  localparam int THR_BITS   = FRAC_BITS;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int MUL_LAT    = 4;                  // fixed-point multiply latency
  localparam int SQ_BITS    = (IW + FRAC_BITS + 1) / 2;
  localparam int DIV_W      = IW + FRAC_BITS - 1; // dividend / quotient width

  localparam logic signed [IW-1:0] S_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] S_MIN = {1'b1, {(IW-1){1'b0}}};

  typedef struct packed {
    logic signed [WORD_BITS-1:0] origin_x;
    logic signed [WORD_BITS-1:0] origin_y;
    logic signed [WORD_BITS-1:0] origin_z;
    logic signed [WORD_BITS-1:0] dir_x;
    logic signed [WORD_BITS-1:0] dir_y;
    logic signed [WORD_BITS-1:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic                 hit;
    logic [DIST_BITS-1:0] distance;
  } out_word_t;

  typedef enum logic [2:0] {
    REG_SLOPE  = 3'd0,
    REG_APEX_X = 3'd1,
    REG_APEX_Y = 3'd2,
    REG_APEX_Z = 3'd3,
    REG_AXIS_X = 3'd4,
    REG_AXIS_Y = 3'd5,
    REG_AXIS_Z = 3'd6,
    REG_THR    = 3'd7
  } reg_idx_e;

  function automatic logic [IW-1:0] smag(logic signed [IW-1:0] x);
    logic [IW-1:0] r;
    r = x[IW-1] ? (~x + 1'b1) : x;
    return r;
  endfunction

  function automatic logic signed [IW-1:0] from_mag(logic neg, logic [IW-1:0] m, logic ovf);
    logic signed [IW-1:0] r;
    if (neg) begin
      r = (ovf || m[IW-1]) ? S_MIN : -$signed(m);
    end else begin
      r = (ovf || m[IW-1]) ? S_MAX : $signed(m);
    end
    return r;
  endfunction

  function automatic logic signed [IW-1:0] sadd(logic signed [IW-1:0] a,
                                                logic signed [IW-1:0] b);
    logic signed [IW:0] s;
    logic signed [IW-1:0] r;
    s = {a[IW-1], a} + {b[IW-1], b};
    if (s[IW] != s[IW-1]) begin
      r = s[IW] ? S_MIN : S_MAX;
    end else begin
      r = s[IW-1:0];
    end
    return r;
  endfunction

  // Negating the most negative value gives the most positive one.
  function automatic logic signed [IW-1:0] ssub(logic signed [IW-1:0] a,
                                                logic signed [IW-1:0] b);
    logic signed [IW-1:0] nb;
    nb = (b == S_MIN) ? S_MAX : -b;
    return sadd(a, nb);
  endfunction

  // Saturated multiply by four.
  function automatic logic signed [IW-1:0] sat4(logic signed [IW-1:0] x);
    logic signed [IW-1:0] r;
    if (x[IW-1] == x[IW-2] && x[IW-1] == x[IW-3]) begin
      r = {x[IW-3:0], 2'b00};
    end else begin
      r = x[IW-1] ? S_MIN : S_MAX;
    end
    return r;
  endfunction

endpackage

### src/rci_fmul.sv
// Pipelined saturating fixed-point multiplier built from four half-width partial products.
module rci_fmul import rci_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [IW-1:0] a_i,
  input  logic signed [IW-1:0] b_i,
  output logic signed [IW-1:0] p_o
);

  localparam int HW = IW / 2;

  logic [IW-1:0]   am_q, bm_q;
  logic            neg1_q, neg2_q, neg3_q;
  logic [IW-1:0]   p00_q, p01_q, p10_q, p11_q;
  logic [2*IW-1:0] full_d, full_q;
  logic signed [IW-1:0] r_d, r_q;

  assign full_d = {p11_q, p00_q}
                + {{HW{1'b0}}, p01_q, {HW{1'b0}}}
                + {{HW{1'b0}}, p10_q, {HW{1'b0}}};

  always_comb begin
    r_d = from_mag(neg3_q, full_q[FRAC_BITS +: IW], |full_q[2*IW-1:FRAC_BITS+IW]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q   <= smag(a_i);
      bm_q   <= smag(b_i);
      neg1_q <= a_i[IW-1] ^ b_i[IW-1];
      p00_q  <= am_q[HW-1:0]  * bm_q[HW-1:0];
      p01_q  <= am_q[HW-1:0]  * bm_q[IW-1:HW];
      p10_q  <= am_q[IW-1:HW] * bm_q[HW-1:0];
      p11_q  <= am_q[IW-1:HW] * bm_q[IW-1:HW];
      neg2_q <= neg1_q;
      full_q <= full_d;
      neg3_q <= neg2_q;
      r_q    <= r_d;
    end
  end

  assign p_o = r_q;

endmodule

### src/rci_div.sv
// Pipelined restoring divider, one quotient bit per stage: |num| * 2^(FRAC_BITS-1) / |den|.
module rci_div import rci_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [IW-1:0] num_i,
  input  logic signed [IW-1:0] den_i,
  output logic [DIV_W-1:0]     quo_o,
  output logic                 neg_o
);

  logic [DIV_W-1:0] qd0_q;
  logic [IW-1:0]    den0_q;
  logic             neg0_q;

  logic [IW-1:0]    rem_q [DIV_W-1];
  logic [IW-1:0]    den_q [DIV_W-1];
  logic [DIV_W-1:0] qd_q  [DIV_W];
  logic             neg_q [DIV_W];

  logic [IW-1:0]    rem_d [DIV_W];
  logic [DIV_W-1:0] qd_d  [DIV_W];

  always_comb begin
    logic [IW-1:0]    rin, din;
    logic [DIV_W-1:0] qin;
    logic [IW:0]      cur;
    for (int j = 0; j < DIV_W; j++) begin
      if (j == 0) begin
        rin = '0;
        din = den0_q;
        qin = qd0_q;
      end else begin
        rin = rem_q[j-1];
        din = den_q[j-1];
        qin = qd_q[j-1];
      end
      cur = {rin, qin[DIV_W-1]};
      if (cur >= {1'b0, din}) begin
        rem_d[j] = IW'(cur - {1'b0, din});
        qd_d[j]  = {qin[DIV_W-2:0], 1'b1};
      end else begin
        rem_d[j] = cur[IW-1:0];
        qd_d[j]  = {qin[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qd0_q  <= {smag(num_i), {(FRAC_BITS-1){1'b0}}};
      den0_q <= smag(den_i);
      neg0_q <= num_i[IW-1] ^ den_i[IW-1];
      for (int j = 0; j < DIV_W; j++) begin
        qd_q[j]  <= qd_d[j];
        neg_q[j] <= (j == 0) ? neg0_q : neg_q[j-1];
      end
      for (int j = 0; j < DIV_W - 1; j++) begin
        rem_q[j] <= rem_d[j];
        den_q[j] <= (j == 0) ? den0_q : den_q[j-1];
      end
    end
  end

  assign quo_o = qd_q[DIV_W-1];
  assign neg_o = neg_q[DIV_W-1];

endmodule

### src/ray_cone_intersect.sv
// Ray against infinite double cone: fully pipelined quadratic, square root and root selection.
//
//   channel   direction  handshake               word
//   --------  ---------  ----------------------  -----------------------------------
//   in        sink       in_valid_i / in_stall_o  in_word_t: ray origin, direction
//   out       source     out_valid_o/out_stall_i  out_word_t: hit, distance
//   cfg       sink       APB psel/penable/pwrite  slope, apex, axis, threshold
//
// One ray enters per cycle unless an output stall freezes the pipe; the pipeline depth is
// set by the bit-per-stage square root and the two bit-per-stage dividers.
// Reset clears the valid pipe and loads the register defaults; payload flops are not reset.
// A stall on the output while a word waits in the output register freezes the whole
// pipe, so nothing is dropped or repeated.
module ray_cone_intersect import rci_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int LAT    = 4*MUL_LAT + 10 + SQ_BITS + DIV_W;
  localparam int DOT_DL = 2 * MUL_LAT;   // plain dots wait for the square and slope products
  localparam int QAB_DL = MUL_LAT + 2;   // qa, qb wait for the discriminant
  localparam int REM_W  = SQ_BITS + 2;
  localparam int RAD_W  = 2 * SQ_BITS;
  // product kinds of the first multiply round
  localparam int K_DN = 0;
  localparam int K_ON = 1;
  localparam int K_DD = 2;
  localparam int K_DO = 3;
  localparam int K_OO = 4;

  // ---------------- configuration registers ----------------
  logic [SLOPE_BITS-1:0]       slope_q;
  logic signed [WORD_BITS-1:0] apex_q [3];
  logic signed [AXIS_BITS-1:0] axis_q [3];
  logic [THR_BITS-1:0]         thr_q;
  reg_idx_e                    cfg_idx;
  logic                        cfg_wr;

  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q   <= SLOPE_BITS'(131072);
      apex_q[0] <= '0;
      apex_q[1] <= '0;
      apex_q[2] <= '0;
      axis_q[0] <= '0;
      axis_q[1] <= AXIS_BITS'(65536);
      axis_q[2] <= '0;
      thr_q     <= THR_BITS'(66);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SLOPE:  slope_q   <= pwdata[SLOPE_BITS-1:0];
        REG_APEX_X: apex_q[0] <= pwdata[WORD_BITS-1:0];
        REG_APEX_Y: apex_q[1] <= pwdata[WORD_BITS-1:0];
        REG_APEX_Z: apex_q[2] <= pwdata[WORD_BITS-1:0];
        REG_AXIS_X: axis_q[0] <= pwdata[AXIS_BITS-1:0];
        REG_AXIS_Y: axis_q[1] <= pwdata[AXIS_BITS-1:0];
        REG_AXIS_Z: axis_q[2] <= pwdata[AXIS_BITS-1:0];
        REG_THR:    thr_q     <= pwdata[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SLOPE:  prdata = DATA_W'(slope_q);
      REG_APEX_X: prdata = DATA_W'(apex_q[0]);
      REG_APEX_Y: prdata = DATA_W'(apex_q[1]);
      REG_APEX_Z: prdata = DATA_W'(apex_q[2]);
      REG_AXIS_X: prdata = DATA_W'(axis_q[0]);
      REG_AXIS_Y: prdata = DATA_W'(axis_q[1]);
      REG_AXIS_Z: prdata = DATA_W'(axis_q[2]);
      REG_THR:    prdata = DATA_W'(thr_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // Single advance enable for every stage; the output register is the last stage.
  logic [LAT-1:0] vld_q;
  logic           adv;

  assign adv        = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // ---------------- entry: direction and origin relative to apex ----------------
  logic signed [WORD_BITS-1:0] d_q  [3];
  logic signed [WORD_BITS:0]   oc_q [3];
  logic signed [WORD_BITS-1:0] org  [3];
  logic signed [WORD_BITS-1:0] dir  [3];

  assign org[0] = in_word_i.origin_x;
  assign org[1] = in_word_i.origin_y;
  assign org[2] = in_word_i.origin_z;
  assign dir[0] = in_word_i.dir_x;
  assign dir[1] = in_word_i.dir_y;
  assign dir[2] = in_word_i.dir_z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k]  <= dir[k];
        oc_q[k] <= (WORD_BITS+1)'(org[k]) - (WORD_BITS+1)'(apex_q[k]);
      end
    end
  end

  // ---------------- round 1: fifteen component products ----------------
  logic signed [IW-1:0] m1a [5][3];
  logic signed [IW-1:0] m1b [5][3];
  logic signed [IW-1:0] r1  [5][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m1a[K_DN][k] = IW'(d_q[k]);  m1b[K_DN][k] = IW'(axis_q[k]);
      m1a[K_ON][k] = IW'(oc_q[k]); m1b[K_ON][k] = IW'(axis_q[k]);
      m1a[K_DD][k] = IW'(d_q[k]);  m1b[K_DD][k] = IW'(d_q[k]);
      m1a[K_DO][k] = IW'(d_q[k]);  m1b[K_DO][k] = IW'(oc_q[k]);
      m1a[K_OO][k] = IW'(oc_q[k]); m1b[K_OO][k] = IW'(oc_q[k]);
    end
  end

  for (genvar c = 0; c < 5; c++) begin : g_m1
    for (genvar k = 0; k < 3; k++) begin : g_k
      rci_fmul u_mul (
        .clk_i (clk_i),
        .en_i  (adv),
        .a_i   (m1a[c][k]),
        .b_i   (m1b[c][k]),
        .p_o   (r1[c][k])
      );
    end
  end

  // dot products, two adds in two stages
  logic signed [IW-1:0] p01_q [5];
  logic signed [IW-1:0] p2_q  [5];
  logic signed [IW-1:0] dot_q [5];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 5; c++) begin
        p01_q[c] <= sadd(r1[c][0], r1[c][1]);
        p2_q[c]  <= r1[c][2];
        dot_q[c] <= sadd(p01_q[c], p2_q[c]);
      end
    end
  end

  // ---------------- rounds 2 and 3: axis terms scaled by the slope ----------------
  logic signed [IW-1:0] m2a [3];
  logic signed [IW-1:0] m2b [3];
  logic signed [IW-1:0] r2  [3];
  logic signed [IW-1:0] r3  [3];

  assign m2a[0] = dot_q[K_DN]; assign m2b[0] = dot_q[K_DN];
  assign m2a[1] = dot_q[K_DN]; assign m2b[1] = dot_q[K_ON];
  assign m2a[2] = dot_q[K_ON]; assign m2b[2] = dot_q[K_ON];

  for (genvar j = 0; j < 3; j++) begin : g_m23
    rci_fmul u_sq (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (m2a[j]),
      .b_i   (m2b[j]),
      .p_o   (r2[j])
    );
    rci_fmul u_slope (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (IW'(slope_q)),
      .b_i   (r2[j]),
      .p_o   (r3[j])
    );
  end

  logic signed [IW-1:0] dot_dl_q [DOT_DL][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        dot_dl_q[0][j] <= dot_q[K_DD + j];
        for (int i = 1; i < DOT_DL; i++) begin
          dot_dl_q[i][j] <= dot_dl_q[i-1][j];
        end
      end
    end
  end

  // ---------------- quadratic coefficients ----------------
  logic signed [IW-1:0] q16_q [3];   // qa, half b, qc
  logic signed [IW-1:0] qa_q, qb_q, qc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        q16_q[j] <= ssub(dot_dl_q[DOT_DL-1][j], r3[j]);
      end
      qa_q <= q16_q[0];
      qb_q <= sadd(q16_q[1], q16_q[1]);
      qc_q <= q16_q[2];
    end
  end

  // ---------------- round 4 and discriminant ----------------
  logic signed [IW-1:0] ac, bb;
  logic signed [IW-1:0] ac4_q, bb_q, disc_q;
  logic signed [IW-1:0] qa_dl_q [QAB_DL];
  logic signed [IW-1:0] qb_dl_q [QAB_DL];

  rci_fmul u_ac (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (qa_q),
    .b_i   (qc_q),
    .p_o   (ac)
  );

  rci_fmul u_bb (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (qb_q),
    .b_i   (qb_q),
    .p_o   (bb)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ac4_q  <= sat4(ac);
      bb_q   <= bb;
      disc_q <= ssub(bb_q, ac4_q);
      qa_dl_q[0] <= qa_q;
      qb_dl_q[0] <= qb_q;
      for (int i = 1; i < QAB_DL; i++) begin
        qa_dl_q[i] <= qa_dl_q[i-1];
        qb_dl_q[i] <= qb_dl_q[i-1];
      end
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  // floor(sqrt(disc * 2^FRAC_BITS)); a negative discriminant runs as zero and is a miss.
  logic [REM_W-1:0]     sq_rem_q  [SQ_BITS-1];
  logic [RAD_W-1:0]     sq_rad_q  [SQ_BITS-1];
  logic [SQ_BITS-1:0]   sq_root_q [SQ_BITS];
  logic signed [IW-1:0] sq_qa_q   [SQ_BITS];
  logic signed [IW-1:0] sq_qb_q   [SQ_BITS];
  logic                 sq_miss_q [SQ_BITS];

  logic [REM_W-1:0]     sq_rem_d  [SQ_BITS];
  logic [RAD_W-1:0]     sq_rad_d  [SQ_BITS];
  logic [SQ_BITS-1:0]   sq_root_d [SQ_BITS];
  logic [IW-1:0]        dpos;
  logic                 miss0;

  assign dpos  = disc_q[IW-1] ? '0 : disc_q;
  assign miss0 = disc_q[IW-1] || (qa_dl_q[QAB_DL-1] == '0);

  always_comb begin
    logic [REM_W-1:0]   rin, cur, trial;
    logic [SQ_BITS-1:0] tin;
    logic [RAD_W-1:0]   din;
    for (int i = 0; i < SQ_BITS; i++) begin
      if (i == 0) begin
        rin = '0;
        tin = '0;
        din = RAD_W'({dpos, {FRAC_BITS{1'b0}}});
      end else begin
        rin = sq_rem_q[i-1];
        tin = sq_root_q[i-1];
        din = sq_rad_q[i-1];
      end
      cur   = {rin[REM_W-3:0], din[RAD_W-1 -: 2]};
      trial = {tin, 2'b01};
      if (cur >= trial) begin
        sq_rem_d[i]  = cur - trial;
        sq_root_d[i] = {tin[SQ_BITS-2:0], 1'b1};
      end else begin
        sq_rem_d[i]  = cur;
        sq_root_d[i] = {tin[SQ_BITS-2:0], 1'b0};
      end
      sq_rad_d[i] = {din[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < SQ_BITS; i++) begin
        sq_root_q[i] <= sq_root_d[i];
      end
      for (int i = 0; i < SQ_BITS - 1; i++) begin
        sq_rem_q[i] <= sq_rem_d[i];
        sq_rad_q[i] <= sq_rad_d[i];
      end
      sq_qa_q[0]   <= qa_dl_q[QAB_DL-1];
      sq_qb_q[0]   <= qb_dl_q[QAB_DL-1];
      sq_miss_q[0] <= miss0;
      for (int i = 1; i < SQ_BITS; i++) begin
        sq_qa_q[i]   <= sq_qa_q[i-1];
        sq_qb_q[i]   <= sq_qb_q[i-1];
        sq_miss_q[i] <= sq_miss_q[i-1];
      end
    end
  end

  // ---------------- root numerators ----------------
  logic signed [IW-1:0] s_val, nb;
  logic signed [IW-1:0] n1_q, n2_q, pqa_q;
  logic                 pmiss_q;

  assign s_val = IW'(sq_root_q[SQ_BITS-1]);
  assign nb    = (sq_qb_q[SQ_BITS-1] == S_MIN) ? S_MAX : -sq_qb_q[SQ_BITS-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q    <= sadd(nb, s_val);
      n2_q    <= ssub(nb, s_val);
      pqa_q   <= sq_qa_q[SQ_BITS-1];
      pmiss_q <= sq_miss_q[SQ_BITS-1];
    end
  end

  // ---------------- the two quotients ----------------
  logic [DIV_W-1:0] quo1, quo2;
  logic             neg1, neg2;
  logic             miss_dl_q [DIV_W+1];

  rci_div u_div1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (n1_q),
    .den_i (pqa_q),
    .quo_o (quo1),
    .neg_o (neg1)
  );

  rci_div u_div2 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (n2_q),
    .den_i (pqa_q),
    .quo_o (quo2),
    .neg_o (neg2)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      miss_dl_q[0] <= pmiss_q;
      for (int i = 1; i <= DIV_W; i++) begin
        miss_dl_q[i] <= miss_dl_q[i-1];
      end
    end
  end

  // ---------------- root selection and output register ----------------
  // Quotients clamp to the positive word range; only positive roots can pass the threshold.
  logic [IW-2:0] t1s, t2s, tsel;
  logic          g1, g2;
  out_word_t     out_d, out_q;

  always_comb begin
    t1s  = (|quo1[DIV_W-1:IW-1]) ? '1 : quo1[IW-2:0];
    t2s  = (|quo2[DIV_W-1:IW-1]) ? '1 : quo2[IW-2:0];
    g1   = !miss_dl_q[DIV_W] && !neg1 && (t1s > (IW-1)'(thr_q));
    g2   = !miss_dl_q[DIV_W] && !neg2 && (t2s > (IW-1)'(thr_q));
    if (g1 && g2) begin
      tsel = (t1s <= t2s) ? t1s : t2s;
    end else if (g1) begin
      tsel = t1s;
    end else begin
      tsel = t2s;
    end
    out_d.hit = g1 | g2;
    if (!(g1 | g2)) begin
      out_d.distance = '0;
    end else if (|tsel[IW-2:DIST_BITS]) begin
      out_d.distance = '1;
    end else begin
      out_d.distance = tsel[DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_word_o  = out_q;

endmodule
